### rtl/nmea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types, constants and character helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nmea_pkg;

  localparam int TAIL_DEPTH = 5;
  localparam int HDR_LEN    = 6;
  localparam int CNT_W      = 7;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [6:0] MIN_LEN_RST = 7'd9;
  localparam logic [6:0] MAX_LEN_RST = 7'd82;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // configuration register indexes
  localparam logic CFG_MIN_LEN = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_NO_DOLLAR = 3'd2,
    ERR_NO_STAR  = 3'd3,
    ERR_BAD_HEX  = 3'd4,
    ERR_CHECKSUM = 3'd5,
    ERR_UNK_TYPE = 3'd6,
    ERR_NO_COMMA = 3'd7
  } err_code_t;

  // sentence type names, index is the reported kind
  localparam logic [3:0][23:0] KIND_NAMES = {
    24'h4D5756,  // MWV
    24'h524D43,  // RMC
    24'h524D42,  // RMB
    24'h415042   // APB
  };

  // sentence state as it stands after the latest character taken
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    logic                            overflow;
    logic                            dollar;
    logic [7:0]                      xor_sum;
    logic [HDR_LEN-1:0][7:0]         hdr;
    logic [TAIL_DEPTH-1:0][7:0]      tail;
  } snap_t;

  typedef struct packed {
    logic       ok;
    err_code_t  err;
    logic [7:0] talker_first;
    logic [7:0] talker_second;
    logic [1:0] kind;
    logic [7:0] rx_sum;
    logic [7:0] cx_sum;
  } result_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    return v[3:0];
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### rtl/nmea_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_chk
// End-of-sentence evaluation: CR/LF strip, length, '$', '*', hex, checksum,
// type and comma checks over the final sentence state.
// ----------------------------------------------------------------------------
module nmea_chk import nmea_pkg::*; (
  input  snap_t      snap,
  input  logic [6:0] min_len,
  input  logic [6:0] max_len,
  output result_t    res
);

  // tail byte k back from the end, zero if that position never arrived or lies beyond the tail depth
  function automatic logic [7:0] tail_at(input snap_t s, input logic [2:0] k);
    logic [7:0] v;
    v = 8'h00;
    if (k < 3'(TAIL_DEPTH) && {4'b0, k} < s.count) v = s.tail[k];
    return v;
  endfunction

  logic [1:0] strip;
  logic [2:0] star_pos;
  logic [7:0] hi_ch;
  logic [7:0] lo_ch;
  logic [7:0] cx;
  logic [1:0] kind;
  logic       matched;

  always_comb begin
    strip = 2'd0;
    if (is_eol(tail_at(snap, 3'd0))) begin
      strip = is_eol(tail_at(snap, 3'd1)) ? 2'd2 : 2'd1;
    end
    star_pos = {1'b0, strip} + 3'd2;
    hi_ch    = tail_at(snap, {1'b0, strip} + 3'd1);
    lo_ch    = tail_at(snap, {1'b0, strip});

    cx = snap.xor_sum;
    for (int k = 0; k < TAIL_DEPTH; k++) begin
      if (3'(k) <= star_pos) cx = cx ^ tail_at(snap, 3'(k));
    end

    // lowest-index matching table entry wins
    kind    = 2'd0;
    matched = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      if ({snap.hdr[2], snap.hdr[3], snap.hdr[4]} == KIND_NAMES[k]) begin
        kind    = 2'(k);
        matched = 1'b1;
      end
    end

    res               = '0;
    res.talker_first  = snap.hdr[0];
    res.talker_second = snap.hdr[1];
    res.kind          = kind;
    res.err           = ERR_NONE;

    if (snap.overflow || snap.count < min_len || snap.count > max_len) begin
      res.err = ERR_LENGTH;
    end else if (!snap.dollar) begin
      res.err = ERR_NO_DOLLAR;
    end else if ({4'b0, star_pos} >= snap.count ||
                 tail_at(snap, star_pos) != CH_STAR) begin
      res.err = ERR_NO_STAR;
    end else begin
      res.cx_sum = cx;
      if (!is_hex(hi_ch) || !is_hex(lo_ch)) begin
        res.err = ERR_BAD_HEX;
      end else begin
        res.rx_sum = {hex_val(hi_ch), hex_val(lo_ch)};
        if (res.rx_sum != cx) res.err = ERR_CHECKSUM;
        else if (!matched) res.err = ERR_UNK_TYPE;
        else if (snap.hdr[5] != CH_COMMA) res.err = ERR_NO_COMMA;
      end
    end
    res.ok = (res.err == ERR_NONE);
  end

endmodule

### rtl/nmea_sentence_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_validator_core
// Streams NMEA 0183 characters one per item and reports one verdict per
// sentence: error code, talker id, type index and both checksums.
// ----------------------------------------------------------------------------
// result: registered into res_r, or into skid_r while the output is stalled, as the final character is accepted
// throughput: one character per cycle while in_stall is low
// a final character waits only while a second result is held behind a stalled one
// reset (rst_n low, synchronous): sentence state and output valid cleared,
// min_length back to 9 and max_length back to 82
module nmea_sentence_validator_core import nmea_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_sentence,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_sentence_ok,
  output logic [2:0] out_error_code,
  output logic [7:0] out_talker_first,
  output logic [7:0] out_talker_second,
  output logic [1:0] out_sentence_kind,
  output logic [7:0] out_received_checksum,
  output logic [7:0] out_computed_checksum
);

  logic [6:0] min_len_r;
  logic [6:0] max_len_r;
  snap_t      st_r;
  snap_t      st_nxt;
  snap_t      snap;
  result_t    res;
  result_t    res_r;
  result_t    skid_r;
  logic       out_valid_r;
  logic       skid_valid_r;
  logic       in_acc;
  logic       res_load;
  logic       out_fire;

  // a final character only waits when both result registers are full
  assign in_stall = skid_valid_r && in_end_of_sentence;
  assign in_acc   = in_valid && !in_stall;
  assign res_load = in_acc && in_end_of_sentence;
  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LEN: min_len_r <= cfg_data;
        CFG_MAX_LEN: max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state after taking the current character
  always_comb begin
    snap = st_r;
    if (!st_r.overflow && st_r.count != COUNT_MAX) begin
      if (st_r.count == '0) snap.dollar = (in_char_byte == CH_DOLLAR);
      else snap.xor_sum = st_r.xor_sum ^ in_char_byte;
      for (int i = 0; i < HDR_LEN; i++) begin
        if (st_r.count == CNT_W'(i + 1)) snap.hdr[i] = in_char_byte;
      end
    end
    snap.tail = {st_r.tail[TAIL_DEPTH-2:0], in_char_byte};
    if (st_r.count == COUNT_MAX) snap.overflow = 1'b1;
    else snap.count = st_r.count + CNT_W'(1);

    st_nxt = st_r;
    if (in_acc) st_nxt = in_end_of_sentence ? '0 : snap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else st_r <= st_nxt;
  end

  nmea_chk u_chk (
    .snap    (snap),
    .min_len (min_len_r),
    .max_len (max_len_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) skid_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
      if (out_valid_r && !out_fire) skid_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // new verdict parks in the skid register while the output is stalled
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) res_r <= skid_r;
    end else if (res_load) begin
      if (out_valid_r && !out_fire) skid_r <= res;
      else res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sentence_ok       = res_r.ok;
  assign out_error_code        = res_r.err;
  assign out_talker_first      = res_r.talker_first;
  assign out_talker_second     = res_r.talker_second;
  assign out_sentence_kind     = res_r.kind;
  assign out_received_checksum = res_r.rx_sum;
  assign out_computed_checksum = res_r.cx_sum;

endmodule
